// ----- hdl/frame_ring_with_crc_check_top_assert.svh -----
// Assertion macros for the frame ring top level.
// Each use samples on clk_i and is disabled while rst_ni is low.
`ifndef FRAME_RING_WITH_CRC_CHECK_TOP_ASSERT_SVH
`define FRAME_RING_WITH_CRC_CHECK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FRP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FRP_ASSERT(name, prop, msg)
`define FRP_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

// ----- hdl/frp_pkg.sv -----
`timescale 1ns / 1ps
package frp_pkg;

  // ring geometry
  localparam int NUM_SLOTS = 64;
  localparam int SLOT_SIZE = 2048;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(2 * NUM_SLOTS);  // head/tail count modulo 2*NUM_SLOTS
  localparam int OFF_W   = $clog2(SLOT_SIZE);      // byte index inside a slot
  localparam int LEN_W   = $clog2(SLOT_SIZE + 1);  // frame length, up to SLOT_SIZE
  localparam int BADDR_W = SLOT_W + OFF_W;
  localparam int BYTE_DEPTH = NUM_SLOTS * (2 ** OFF_W);

  // fixed field widths
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 4;
  localparam int USED_W  = 7;
  localparam int CRC_W   = 32;

  localparam logic [CFG_W-1:0] MAX_LEN_RST = 12'd1518;
  localparam logic [CFG_W-1:0] RD_CAP_RST  = 12'd2048;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAME_LEN = 4'd0,
    CFG_READER_CAP    = 4'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_REJECTED = 3'd3,
    STAT_CRC_BAD  = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              frame_end;
    logic [2:0]        status;
    logic [USED_W-1:0] used_slots;
    logic [31:0]       drop_count;
  } out_item_t;

  // per-slot descriptor: stored length and final CRC
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CRC_W-1:0] crc;
  } desc_t;

  typedef struct packed {
    logic               we;
    logic [BADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BADDR_W-1:0] raddr;
  } byte_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    desc_t             wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } desc_req_t;

  // reflected CRC-32, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [CNT_W-1:0] cnt_next(input logic [CNT_W-1:0] c);
    return (c == CNT_W'(2 * NUM_SLOTS - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = (c >= CNT_W'(NUM_SLOTS)) ? c - CNT_W'(NUM_SLOTS) : c;
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] used_of(input logic [CNT_W-1:0] h,
                                               input logic [CNT_W-1:0] t);
    logic [CNT_W:0] d;
    d = (h >= t) ? {1'b0, h} - {1'b0, t}
                 : {1'b0, h} + (CNT_W + 1)'(2 * NUM_SLOTS) - {1'b0, t};
    return d[CNT_W-1:0];
  endfunction

endpackage

// ----- hdl/frp_ram.sv -----
`timescale 1ns / 1ps
// simple dual port RAM, registered read
module frp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/frp_ctrl.sv -----
`timescale 1ns / 1ps
module frp_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  frp_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output frp_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frp_pkg::CFG_W-1:0]    cfg_wdata_i,
  output frp_pkg::byte_req_t           byte_req_o,
  input  logic [7:0]                   byte_rdata_i,
  output frp_pkg::desc_req_t           desc_req_o,
  input  frp_pkg::desc_t               desc_rdata_i
);
  import frp_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [LEN_W-1:0] push_off_q, push_off_d, pull_off_q, pull_off_d;
  logic [CRC_W-1:0] push_crc_q, push_crc_d, pull_crc_q, pull_crc_d;
  logic             push_disc_q, push_disc_d;
  logic [31:0]      drops_q, drops_d;
  logic [CFG_W-1:0] max_len_q, rd_cap_q;
  logic             out_valid_q, out_load;
  out_item_t        out_q, out_d;

  logic [CNT_W-1:0] used;
  logic             out_free, accept, drop_now, discard, reject, pull_last;
  logic [CRC_W-1:0] push_crc_nx, pull_crc_nx;
  logic [LEN_W-1:0] push_off_inc, pull_off_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
      rd_cap_q  <= RD_CAP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_FRAME_LEN: max_len_q <= cfg_wdata_i;
        CFG_READER_CAP:    rd_cap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign used         = used_of(head_q, tail_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_IDLE) && out_free;
  assign accept       = in_valid_i && in_ready_o;

  // drop check: full at frame start, or frame grows past either limit
  assign drop_now = !push_disc_q &&
                    (((push_off_q == '0) && (used >= CNT_W'(NUM_SLOTS))) ||
                     ({{(LEN_W > CFG_W ? 0 : CFG_W - LEN_W){1'b0}}, push_off_q} >=
                      {{(CFG_W > LEN_W ? 0 : LEN_W - CFG_W){1'b0}}, max_len_q}) ||
                     (push_off_q >= LEN_W'(SLOT_SIZE)));
  assign discard      = push_disc_q || drop_now;
  assign push_crc_nx  = crc_byte(push_crc_q, in_data_i.data_byte);
  assign push_off_inc = push_off_q + 1'b1;

  assign pull_crc_nx  = crc_byte(pull_crc_q, byte_rdata_i);
  assign pull_off_inc = pull_off_q + 1'b1;
  assign reject = (pull_off_q == '0) &&
                  ((desc_rdata_i.len == '0) ||
                   (desc_rdata_i.len > max_len_q) ||
                   (desc_rdata_i.len > rd_cap_q) ||
                   (desc_rdata_i.len > LEN_W'(SLOT_SIZE)));
  assign pull_last = pull_off_inc >= desc_rdata_i.len;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    push_off_d  = push_off_q;
    push_crc_d  = push_crc_q;
    push_disc_d = push_disc_q;
    pull_off_d  = pull_off_q;
    pull_crc_d  = pull_crc_q;
    drops_d     = drops_q;
    out_load    = 1'b0;
    out_d       = out_q;

    byte_req_o.we    = 1'b0;
    byte_req_o.waddr = {slot_of(head_q), push_off_q[OFF_W-1:0]};
    byte_req_o.wdata = in_data_i.data_byte;
    byte_req_o.re    = 1'b0;
    byte_req_o.raddr = {slot_of(tail_q), pull_off_q[OFF_W-1:0]};
    desc_req_o.we    = 1'b0;
    desc_req_o.waddr = slot_of(head_q);
    desc_req_o.wdata = '{len: push_off_inc, crc: ~push_crc_nx};
    desc_req_o.re    = 1'b0;
    desc_req_o.raddr = slot_of(tail_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.out_byte   = '0;
          out_d.byte_valid = 1'b0;
          out_d.frame_end  = 1'b0;
          out_d.status     = STAT_OK;
          if (in_data_i.mode == MODE_PUSH) begin
            out_load = 1'b1;
            if (drop_now) begin
              drops_d = drops_q + 1'b1;
            end
            if (discard) begin
              out_d.status = STAT_DROPPED;
              push_disc_d  = !in_data_i.last_byte;
              if (in_data_i.last_byte) begin
                push_off_d = '0;
                push_crc_d = CRC_ONES;
              end
            end else begin
              byte_req_o.we = 1'b1;
              if (in_data_i.last_byte) begin
                desc_req_o.we = 1'b1;
                head_d        = cnt_next(head_q);
                push_off_d    = '0;
                push_crc_d    = CRC_ONES;
              end else begin
                push_off_d = push_off_inc;
                push_crc_d = push_crc_nx;
              end
            end
          end else if (used == '0) begin
            out_load     = 1'b1;
            out_d.status = STAT_EMPTY;
          end else begin
            // fetch descriptor and byte, finish in ST_READ once the output is free
            byte_req_o.re = 1'b1;
            desc_req_o.re = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load         = 1'b1;
          state_d          = ST_IDLE;
          out_d.out_byte   = '0;
          out_d.byte_valid = 1'b0;
          out_d.frame_end  = 1'b0;
          out_d.status     = STAT_OK;
          if (reject) begin
            out_d.status = STAT_REJECTED;
            tail_d       = cnt_next(tail_q);
            pull_crc_d   = CRC_ONES;
          end else begin
            out_d.out_byte   = byte_rdata_i;
            out_d.byte_valid = 1'b1;
            if (pull_last) begin
              out_d.frame_end = 1'b1;
              if (~pull_crc_nx != desc_rdata_i.crc) begin
                out_d.status = STAT_CRC_BAD;
              end
              tail_d     = cnt_next(tail_q);
              pull_off_d = '0;
              pull_crc_d = CRC_ONES;
            end else begin
              pull_off_d = pull_off_inc;
              pull_crc_d = pull_crc_nx;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_d.used_slots = USED_W'(used_of(head_d, tail_d));
      out_d.drop_count = drops_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      push_off_q  <= '0;
      push_crc_q  <= CRC_ONES;
      push_disc_q <= 1'b0;
      pull_off_q  <= '0;
      pull_crc_q  <= CRC_ONES;
      drops_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      push_off_q  <= push_off_d;
      push_crc_q  <= push_crc_d;
      push_disc_q <= push_disc_d;
      pull_off_q  <= pull_off_d;
      pull_crc_q  <= pull_crc_d;
      drops_q     <= drops_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/frame_ring_with_crc_check_top.sv -----
`timescale 1ns / 1ps
// Frame ring with CRC-32 check. Push items write frame bytes into the slot at
// the head of a 64-slot ring (2048 bytes per slot) while a reflected CRC-32
// runs; the final byte stores length and CRC in a descriptor and advances the
// head. Frames that meet a full ring or exceed the length limit are dropped
// and counted. Pull items return the frame at the tail one byte per item; the
// last byte reports a CRC mismatch, bad stored lengths skip the frame as
// rejected. Every item yields exactly one result item. A pull from a
// non-empty ring (a byte or a rejected frame) passes through the read state
// for the registered read of the byte and descriptor RAMs; no new item is
// taken there, nor while the output stalls. The output register lets the
// next item be taken in the cycle the previous result is taken. The RAMs
// need no clearing pass after reset: a slot is only read after a push filled
// it. Configuration (index 0 max frame length, index 1 reader capacity, low
// 12 bits kept) must be written only while idle; the block does not enforce it.
`include "frame_ring_with_crc_check_top_assert.svh"
module frame_ring_with_crc_check_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  frp_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output frp_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frp_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import frp_pkg::*;

  byte_req_t  byte_req;
  desc_req_t  desc_req;
  logic [7:0] byte_rdata;
  desc_t      desc_rdata;

  // sequencer: push/pull control, counters, CRC and output register
  frp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_req_o   (byte_req),
    .byte_rdata_i (byte_rdata),
    .desc_req_o   (desc_req),
    .desc_rdata_i (desc_rdata)
  );

  // frame bytes, slot index in the upper address bits
  frp_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_req.we),
    .waddr_i (byte_req.waddr),
    .wdata_i (byte_req.wdata),
    .re_i    (byte_req.re),
    .raddr_i (byte_req.raddr),
    .rdata_o (byte_rdata)
  );

  // per-slot length and CRC
  frp_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (NUM_SLOTS)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_req.we),
    .waddr_i (desc_req.waddr),
    .wdata_i (desc_req.wdata),
    .re_i    (desc_req.re),
    .raddr_i (desc_req.raddr),
    .rdata_o (desc_rdata)
  );

  // push writes and pull reads never share a cycle
  `FRP_ASSERT(a_no_rw_overlap, !((byte_req.we || desc_req.we) && (byte_req.re || desc_req.re)), "RAM write and read in same cycle")
  // held frames never exceed the ring size
  `FRP_ASSERT_IMPL(a_used_bound, out_valid_o, out_data_o.used_slots <= NUM_SLOTS, "used_slots above ring size")
  // a frame end always carries a byte
  `FRP_ASSERT_IMPL(a_end_has_byte, out_valid_o && out_data_o.frame_end, out_data_o.byte_valid, "frame_end without byte")
  // a read is issued only for an offered pull item
  `FRP_ASSERT_IMPL(a_read_from_pull, byte_req.re, in_valid_i && in_data_i.mode == MODE_PULL, "RAM read without pull item")

endmodule

// ----- sim/frame_ring_checker.sv -----
`timescale 1ns / 1ps
module frame_ring_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  frp_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  frp_pkg::out_item_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          drain_done_i,
  output int                            mismatches_o,
  output int                            owed_o,
  output int                            checked_o
);
  import frp_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [7:0]       frame_mem [NUM_SLOTS*SLOT_SIZE];
  int unsigned      stored_len [NUM_SLOTS];
  logic [CRC_W-1:0] stored_crc [NUM_SLOTS];
  logic [CNT_W-1:0] head_cnt, tail_cnt;
  logic [LEN_W-1:0] wr_off, rd_off;
  logic [CRC_W-1:0] wr_crc, rd_crc;
  logic             dropping;
  logic [31:0]      drop_total;
  // kept as int; the 12-bit port values and the reset values all fit
  int unsigned      max_len_reg, rd_cap_reg;

  out_item_t        owed_results [$];
  int               n_bad, n_checked;
  bit               leftovers_done;

  function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] acc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ CRC_W'(b);
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
    return r;
  endfunction

  // counts run modulo 2**CNT_W, so a plain difference wraps right
  function automatic logic [CNT_W-1:0] frames_held();
    return head_cnt - tail_cnt;
  endfunction

  task automatic reset_ring();
    head_cnt    = '0;
    tail_cnt    = '0;
    wr_off      = '0;
    rd_off      = '0;
    wr_crc      = CRC_ONES;
    rd_crc      = CRC_ONES;
    dropping    = 1'b0;
    drop_total  = '0;
    max_len_reg = 1518;
    rd_cap_reg  = 2048;
  endtask

  task automatic close_push_frame();
    wr_off   = '0;
    wr_crc   = CRC_ONES;
    dropping = 1'b0;
  endtask

  task automatic predict_ring_item(input in_item_t it, output out_item_t res);
    status_e           st;
    int unsigned       limit, len;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        rd;
    res = '0;
    if (it.mode == MODE_PUSH) begin
      if (!dropping) begin
        limit = (max_len_reg < SLOT_SIZE) ? max_len_reg : SLOT_SIZE;
        if ((wr_off == 0 && frames_held() >= NUM_SLOTS) || wr_off >= limit) begin
          dropping   = 1'b1;
          drop_total = drop_total + 1;
        end
      end
      if (dropping) begin
        st = STAT_DROPPED;
        if (it.last_byte) close_push_frame();
      end else begin
        st   = STAT_OK;
        slot = head_cnt[SLOT_W-1:0];
        frame_mem[{slot, wr_off[OFF_W-1:0]}] = it.data_byte;
        wr_crc = crc32_step(wr_crc, it.data_byte);
        wr_off = wr_off + 1'b1;
        if (it.last_byte) begin
          stored_len[slot] = wr_off;
          stored_crc[slot] = wr_crc ^ CRC_ONES;
          head_cnt = head_cnt + 1'b1;
          close_push_frame();
        end
      end
    end else if (frames_held() == 0) begin
      st = STAT_EMPTY;
    end else begin
      slot = tail_cnt[SLOT_W-1:0];
      len  = stored_len[slot];
      if (rd_off == 0 &&
          (len == 0 || len > max_len_reg || len > rd_cap_reg || len > SLOT_SIZE)) begin
        tail_cnt = tail_cnt + 1'b1;
        rd_crc   = CRC_ONES;
        st       = STAT_REJECTED;
      end else begin
        rd = frame_mem[{slot, rd_off[OFF_W-1:0]}];
        res.out_byte   = rd;
        res.byte_valid = 1'b1;
        rd_crc = crc32_step(rd_crc, rd);
        rd_off = rd_off + 1'b1;
        st     = STAT_OK;
        if (rd_off >= len) begin
          res.frame_end = 1'b1;
          if ((rd_crc ^ CRC_ONES) != stored_crc[slot]) st = STAT_CRC_BAD;
          tail_cnt = tail_cnt + 1'b1;
          rd_off   = '0;
          rd_crc   = CRC_ONES;
        end
      end
    end
    res.status     = st;
    res.used_slots = USED_W'(frames_held());
    res.drop_count = drop_total;
  endtask

  task automatic log_mismatch(input string what);
    if (n_bad < MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, what);
    n_bad++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t pred;
    if (!rst_ni) begin
      reset_ring();
      owed_results.delete();
      n_bad          = 0;
      n_checked      = 0;
      leftovers_done = 1'b0;
    end else begin
      // compare first: a result never belongs to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        n_checked++;
        if (owed_results.size() == 0) begin
          log_mismatch("result with no item outstanding");
        end else begin
          want = owed_results.pop_front();
          compare_field("out_byte", out_data_i.out_byte, want.out_byte);
          compare_field("byte_valid", out_data_i.byte_valid, want.byte_valid);
          compare_field("frame_end", out_data_i.frame_end, want.frame_end);
          compare_field("status", out_data_i.status, want.status);
          compare_field("used_slots", out_data_i.used_slots, want.used_slots);
          compare_field("drop_count", out_data_i.drop_count, want.drop_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_ring_item(in_data_i, pred);
        owed_results.push_back(pred);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_FRAME_LEN: max_len_reg = cfg_wdata_i;
          CFG_READER_CAP:    rd_cap_reg  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (drain_done_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (owed_results.size() != 0)
          log_mismatch($sformatf("%0d results never arrived", owed_results.size()));
      end
    end
    mismatches_o <= n_bad;
    owed_o       <= owed_results.size();
    checked_o    <= n_checked;
  end

endmodule

// ----- sim/frame_ring_with_crc_check_top_tb.sv -----
`timescale 1ns / 1ps
module frame_ring_with_crc_check_top_tb;
  import frp_pkg::*;

  // quiet cycles allowed: longest receiver hold-off plus stalls, with margin
  localparam int WATCHDOG_LIMIT = 2000;
  // index past the register list; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 drain_done;

  int mismatches, owed, checked;

  // knobs shared between the stimulus and the receiver
  bit tx_idles    = 1'b1;
  bit rx_idles    = 1'b1;
  int rx_hold_len = 0;

  int items_sent, pushes_sent, pulls_sent, settings_used;
  int empties_seen;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_ring_with_crc_check_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  frame_ring_checker ring_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .drain_done_i (drain_done),
    .mismatches_o (mismatches),
    .owed_o       (owed),
    .checked_o    (checked)
  );

  // Empty-ring results tell the stimulus when a drain has finished; only
  // timing depends on this, never the checked values.
  always @(posedge clk) begin
    if (out_valid && out_ready && out_data.status == STAT_EMPTY) empties_seen++;
  end

  // Watchdog: any handshake resets the quiet counter.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on
  // request. The hold-off is counted here, independent of the sender.
  initial begin : receiver
    int stall;
    int n;
    stall = 0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (rx_idles && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item and return at the edge that takes it. Valid stays high on
  // return so back-to-back items need no extra assignment; callers that wait
  // for anything else lower it first, in the same step.
  task automatic send_item(input logic m, input logic [7:0] b, input logic l);
    in_item_t it;
    int gap;
    if (tx_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
    it.mode      = m;
    it.data_byte = b;
    it.last_byte = l;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (m == MODE_PUSH) pushes_sent++;
    else pulls_sent++;
  endtask

  task automatic push_frame(input int len);
    for (int i = 0; i < len; i++) send_item(MODE_PUSH, 8'($urandom), i == len - 1);
  endtask

  // data and last are don't-care on a pull, so toggle them anyway
  task automatic pull_items(input int n);
    for (int i = 0; i < n; i++) send_item(MODE_PULL, 8'($urandom), 1'($urandom));
  endtask

  // Sender pause: hold off until every outstanding result is back, then a few
  // more cycles to cover the read path.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only while the block is idle.
  task automatic write_regs(input logic [CFG_W-1:0] max_len, input logic [CFG_W-1:0] cap,
                            input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     val [3];
    int n;
    wait_idle();
    idx[0] = CFG_MAX_FRAME_LEN;
    val[0] = max_len;
    idx[1] = CFG_READER_CAP;
    val[1] = cap;
    // a write that aliases onto the capacity would reject nearly everything
    idx[2] = CFG_SPARE_IDX;
    val[2] = 12'd1;
    n = poke_spare ? 3 : 2;
    for (int k = 0; k < n; k++) begin
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Pull until an empty result shows up; later pulls in flight just see empty.
  task automatic drain_ring();
    int base;
    base = empties_seen;
    while (empties_seen == base) send_item(MODE_PULL, 8'($urandom), 1'($urandom));
  endtask

  // Close any half-pushed frame, then empty the ring, for a known start.
  task automatic settle_ring();
    send_item(MODE_PUSH, 8'($urandom), 1'b1);
    drain_ring();
  endtask

  // Mostly well-formed traffic: whole frames and pull bursts about one frame
  // long, some oversize frames, and a tenth single random items (which can
  // leave a frame open for the next push to extend).
  task automatic random_traffic(input int n, input int max_len);
    int stop, r, len;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_len)
                                          : $urandom_range(1, max_len);
        push_frame(len);
      end else if (r < 90) begin
        pull_items($urandom_range(1, max_len));
      end else begin
        send_item($urandom_range(0, 1) ? MODE_PULL : MODE_PUSH, 8'($urandom),
                  1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    drain_done <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: pull from empty, a one-byte frame,
    // a short frame with extreme bytes, read both back, empty again.
    send_item(MODE_PULL, 8'hFF, 1'b1);
    send_item(MODE_PUSH, 8'h00, 1'b1);
    send_item(MODE_PUSH, 8'hFF, 1'b0);
    send_item(MODE_PUSH, 8'h5A, 1'b0);
    send_item(MODE_PUSH, 8'hA5, 1'b1);
    send_item(MODE_PULL, 8'h00, 1'b0);
    pull_items(3);
    send_item(MODE_PULL, 8'h00, 1'b0);

    // Ring full: 66 one-byte frames into an empty ring, two three-byte frames
    // that must each be dropped once, then read everything out.
    for (int i = 0; i < 66; i++) send_item(MODE_PUSH, 8'($urandom), 1'b1);
    push_frame(3);
    push_frame(3);
    pull_items(70);

    // Backpressure: the receiver holds off while the sender keeps offering,
    // so the output register fills and input stalls; then the sender pauses
    // until everything is back.
    rx_hold_len = 250;
    push_frame(20);
    pull_items(25);
    wait_idle();

    random_traffic(120, 16);

    // Short frame limit: frames past 8 bytes get dropped mid-frame.
    write_regs(12'd8, 12'd4095, 1'b0);
    tx_idles = 1'b0;
    random_traffic(80, 12);
    tx_idles = 1'b1;

    // Rejected lengths: store frames of 3, 10 and 12 bytes, then shrink the
    // capacity and then the frame limit under them.
    settle_ring();
    write_regs(12'd12, 12'd4095, 1'b0);
    push_frame(3);
    push_frame(10);
    push_frame(12);
    write_regs(12'd12, 12'd5, 1'b0);
    pull_items(3);
    pull_items(1);
    write_regs(12'd11, 12'd4095, 1'b1);
    pull_items(2);
    push_frame(3);
    pull_items(4);

    // Smallest nonzero limits: only one-byte frames survive.
    write_regs(12'd1, 12'd1, 1'b0);
    rx_idles = 1'b0;
    random_traffic(50, 3);
    rx_idles = 1'b1;

    // Zero limit drops every frame; zero capacity rejects every stored frame.
    write_regs(12'd0, 12'd0, 1'b0);
    random_traffic(30, 4);
    write_regs(12'd4095, 12'd0, 1'b0);
    random_traffic(30, 4);

    // Closing stretch: capacity below the frame limit, idling off at the end.
    write_regs(12'd64, 12'd40, 1'b0);
    random_traffic(80, 24);
    tx_idles = 1'b0;
    rx_idles = 1'b0;
    random_traffic(60, 24);

    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("covered %0d items (%0d push, %0d pull) over %0d register settings",
             items_sent, pushes_sent, pulls_sent, settings_used + 1);
    $display("%0d results compared; full ring, oversize, rejected and empty paths hit",
             checked);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
